>>> sv/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, ignored while reset is asserted.
`define MFBH_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define MFBH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/mfbh_pkg.sv
package mfbh_pkg;

    localparam int MAX_ADDR_BITS = 32;
    localparam int DATA_BITS     = 8;
    localparam int COUNT_WIDTH   = 32;

    // One memory row per (address bit, address bit value); lanes are (data bit, expect bit).
    localparam int LANES   = DATA_BITS * 2;
    localparam int LANE_W  = $clog2(LANES);
    localparam int ROWS    = MAX_ADDR_BITS * 2;
    localparam int ROW_AW  = $clog2(ROWS);
    localparam int ABIT_W  = 5;
    localparam int TRACK_W = 6;
    localparam int OUT_W   = 32;

    localparam logic [TRACK_W-1:0] RESET_TRACK_BITS = TRACK_W'(32);
    localparam int REG_TRACK_BITS = 0;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef struct packed {
        t_count fail;
        t_count test;
    } t_pair;

    typedef t_pair [LANES-1:0] t_row;

    localparam t_count COUNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        TGT_TEST        = 2'd0,
        TGT_FAIL        = 2'd1,
        TGT_TESTS_TOTAL = 2'd2,
        TGT_FAILS_TOTAL = 2'd3
    } t_target;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_READ,
        S_READ_DATA,
        S_DONE
    } t_state;

    function automatic t_count sat_inc(t_count c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic t_count sat_add(t_count c, logic [2:0] n);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, c} + (COUNT_WIDTH + 1)'(n);
        return s[COUNT_WIDTH] ? COUNT_MAX : s[COUNT_WIDTH-1:0];
    endfunction

    // Clamp a counter to the 32-bit result field.
    function automatic logic [OUT_W-1:0] sat_out(t_count c);
        logic [COUNT_WIDTH+OUT_W-1:0] wide;
        wide = {{OUT_W{1'b0}}, c};
        return (wide[COUNT_WIDTH+OUT_W-1:OUT_W] != '0) ? '1 : wide[OUT_W-1:0];
    endfunction

endpackage

>>> sv/mfbh_ram.sv
module mfbh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/mfbh_row_update.sv
module mfbh_row_update (
    input  mfbh_pkg::t_row                   i_old,
    input  logic [mfbh_pkg::DATA_BITS-1:0]   i_expect,
    input  logic [mfbh_pkg::DATA_BITS-1:0]   i_receive,
    output mfbh_pkg::t_row                   o_new
);

    // Each data bit bumps the lane picked by its expected value.
    always_comb begin
        o_new = i_old;
        for (int d = 0; d < mfbh_pkg::DATA_BITS; d++) begin
            for (int ds = 0; ds < 2; ds++) begin
                if (i_expect[d] == 1'(ds)) begin
                    o_new[d*2+ds].test = mfbh_pkg::sat_inc(i_old[d*2+ds].test);
                    if (i_expect[d] != i_receive[d]) begin
                        o_new[d*2+ds].fail = mfbh_pkg::sat_inc(i_old[d*2+ds].fail);
                    end
                end
            end
        end
    end

endmodule

>>> sv/memory_fail_bit_histogram.sv
// Fail-bit histogram for memory test results. A record beat (op 0) splits a byte, halfword or
// word access into bytes and, for every tracked address bit and every data bit, bumps a
// saturating test counter and, on a mismatch, the matching fail counter; misaligned or
// invalid sizes are rejected and flagged. While a record runs, the histogram memory reads,
// updates and writes back one counter row per cycle. Clear is instant: each of the 64 rows
// carries a valid bit, so no clearing pass runs after reset. The single register, the
// tracked address-bit count at offset 0, must be written over the APB port only while the
// block is idle; the block itself does not enforce this.
module memory_fail_bit_histogram (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [1:0]  i_access_size,
    input  logic [31:0] i_address,
    input  logic [31:0] i_expected_data,
    input  logic [31:0] i_received_data,
    input  logic [1:0]  i_read_target,
    input  logic [4:0]  i_addr_bit_index,
    input  logic        i_addr_bit_state,
    input  logic [2:0]  i_data_bit_index,
    input  logic        i_data_bit_state,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_count_value,
    output logic        o_any_mismatch,
    output logic        o_misaligned,
    output logic [2:0]  o_bytes_failed
);

    localparam int DB = mfbh_pkg::DATA_BITS;

    mfbh_pkg::t_state r_state, n_state;

    logic [mfbh_pkg::TRACK_W-1:0] r_abc;
    logic [mfbh_pkg::TRACK_W-1:0] tracked;
    logic                         cfg_hit;
    logic                         cfg_wr;

    logic [31:0]                  r_address, r_expect, r_receive;
    mfbh_pkg::t_target            r_target;
    logic [mfbh_pkg::ROW_AW-1:0]  r_rd_row;
    logic [mfbh_pkg::LANE_W-1:0]  r_rd_lane;
    logic                         r_rd_ok;
    logic [1:0]                   r_last_byte, r_byte;
    logic [mfbh_pkg::ABIT_W-1:0]  r_last_abit, r_abit;

    mfbh_pkg::t_count             r_tests_total, r_fails_total;
    logic [31:0]                  r_res_count;
    logic                         r_res_any, r_res_mis;
    logic [2:0]                   r_res_bytes;

    logic                         r_out_valid;
    logic [31:0]                  r_out_count;
    logic                         r_out_any, r_out_mis;
    logic [2:0]                   r_out_bytes;

    logic                         r_p1_valid;
    logic [mfbh_pkg::ROW_AW-1:0]  r_p1_row;
    logic [DB-1:0]                r_p1_exp, r_p1_rcv;
    logic                         r_fwd_valid;
    mfbh_pkg::t_row               r_fwd_row;
    logic [mfbh_pkg::ROWS-1:0]    r_row_valid;

    mfbh_pkg::t_op                in_op;
    mfbh_pkg::t_target            in_target;
    logic [2:0]                   nbytes;
    logic                         mis;
    logic [3:0]                   byte_bad;
    logic [2:0]                   nfail;
    logic                         accept, step_issue, load_out;

    logic [31:0]                  byte_addr;
    logic                         step_bit_val;
    logic [mfbh_pkg::ROW_AW-1:0]  issue_row, ram_raddr;
    logic [$bits(mfbh_pkg::t_row)-1:0] ram_q;
    mfbh_pkg::t_row               old_row, new_row, rd_row;
    mfbh_pkg::t_pair              rd_pair;
    mfbh_pkg::t_count             rd_val;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == 1'(mfbh_pkg::REG_TRACK_BITS));
    assign cfg_wr  = psel & penable & pwrite & cfg_hit;
    assign prdata  = cfg_hit ? {{(32 - mfbh_pkg::TRACK_W){1'b0}}, r_abc} : 32'd0;
    assign tracked = (r_abc > mfbh_pkg::TRACK_W'(mfbh_pkg::MAX_ADDR_BITS))
                   ? mfbh_pkg::TRACK_W'(mfbh_pkg::MAX_ADDR_BITS) : r_abc;

    // Decode of the incoming beat
    assign in_op     = mfbh_pkg::t_op'(i_op);
    assign in_target = mfbh_pkg::t_target'(i_read_target);

    always_comb begin
        case (i_access_size)
            mfbh_pkg::SIZE_BYTE: begin
                nbytes = 3'd1;
                mis    = 1'b0;
            end
            mfbh_pkg::SIZE_HALF: begin
                nbytes = 3'd2;
                mis    = i_address[0];
            end
            mfbh_pkg::SIZE_WORD: begin
                nbytes = 3'd4;
                mis    = (i_address[1:0] != 2'd0);
            end
            default: begin
                nbytes = 3'd0;
                mis    = 1'b1;
            end
        endcase
        for (int i = 0; i < 4; i++) begin
            byte_bad[i] = (3'(i) < nbytes)
                        && (i_expected_data[i*8 +: 8] != i_received_data[i*8 +: 8]);
        end
        nfail = 3'($countones(byte_bad));
    end

    // Step address: aligned access, so the byte offset never carries
    assign byte_addr    = {r_address[31:2], r_address[1:0] | r_byte};
    assign step_bit_val = byte_addr[r_abit];
    assign issue_row    = mfbh_pkg::ROW_AW'({r_abit, step_bit_val});
    assign ram_raddr    = (r_state == mfbh_pkg::S_READ) ? r_rd_row : issue_row;

    mfbh_ram #(
        .WIDTH ($bits(mfbh_pkg::t_row)),
        .DEPTH (mfbh_pkg::ROWS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (r_p1_valid),
        .i_waddr (r_p1_row),
        .i_wdata (new_row),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // Forward the row written last cycle when the same row is read back-to-back
    assign old_row = r_fwd_valid ? r_fwd_row
                   : (r_row_valid[r_p1_row] ? mfbh_pkg::t_row'(ram_q) : '0);

    mfbh_row_update u_row_update (
        .i_old     (old_row),
        .i_expect  (r_p1_exp),
        .i_receive (r_p1_rcv),
        .o_new     (new_row)
    );

    assign rd_row  = r_row_valid[r_rd_row] ? mfbh_pkg::t_row'(ram_q) : '0;
    assign rd_pair = rd_row[r_rd_lane];
    assign rd_val  = !r_rd_ok ? '0
                   : ((r_target == mfbh_pkg::TGT_TEST) ? rd_pair.test : rd_pair.fail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfbh_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = (r_state == mfbh_pkg::S_IDLE);
        accept     = (r_state == mfbh_pkg::S_IDLE) && i_in_valid;
        step_issue = (r_state == mfbh_pkg::S_RUN);
        load_out   = (r_state == mfbh_pkg::S_DONE) && (!r_out_valid || i_out_ready);
        case (r_state)
            mfbh_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (in_op)
                        mfbh_pkg::OP_RECORD: begin
                            n_state = (!mis && tracked != '0) ? mfbh_pkg::S_RUN
                                                               : mfbh_pkg::S_DONE;
                        end
                        mfbh_pkg::OP_READ: begin
                            n_state = (in_target == mfbh_pkg::TGT_TEST ||
                                       in_target == mfbh_pkg::TGT_FAIL)
                                    ? mfbh_pkg::S_READ : mfbh_pkg::S_DONE;
                        end
                        default: n_state = mfbh_pkg::S_DONE;
                    endcase
                end
            end
            mfbh_pkg::S_RUN: begin
                if (r_abit == r_last_abit && r_byte == r_last_byte) begin
                    n_state = mfbh_pkg::S_DRAIN;
                end
            end
            mfbh_pkg::S_DRAIN:     n_state = mfbh_pkg::S_DONE;
            mfbh_pkg::S_READ:      n_state = mfbh_pkg::S_READ_DATA;
            mfbh_pkg::S_READ_DATA: n_state = mfbh_pkg::S_DONE;
            mfbh_pkg::S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = mfbh_pkg::S_IDLE;
                end
            end
            default: n_state = mfbh_pkg::S_IDLE;
        endcase
    end

    // Control and counter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abc         <= mfbh_pkg::RESET_TRACK_BITS;
            r_out_valid   <= 1'b0;
            r_p1_valid    <= 1'b0;
            r_fwd_valid   <= 1'b0;
            r_row_valid   <= '0;
            r_tests_total <= '0;
            r_fails_total <= '0;
        end else begin
            if (cfg_wr) begin
                r_abc <= pwdata[mfbh_pkg::TRACK_W-1:0];
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            r_p1_valid  <= step_issue;
            r_fwd_valid <= step_issue && r_p1_valid && (issue_row == r_p1_row);
            if (accept && in_op == mfbh_pkg::OP_CLEAR) begin
                r_row_valid <= '0;
            end else if (r_p1_valid) begin
                r_row_valid[r_p1_row] <= 1'b1;
            end
            if (accept && in_op == mfbh_pkg::OP_CLEAR) begin
                r_tests_total <= '0;
                r_fails_total <= '0;
            end else if (accept && in_op == mfbh_pkg::OP_RECORD && !mis) begin
                r_tests_total <= mfbh_pkg::sat_add(r_tests_total, nbytes);
                r_fails_total <= mfbh_pkg::sat_add(r_fails_total, nfail);
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_address   <= i_address;
            r_expect    <= i_expected_data;
            r_receive   <= i_received_data;
            r_target    <= in_target;
            r_rd_row    <= mfbh_pkg::ROW_AW'({i_addr_bit_index, i_addr_bit_state});
            r_rd_lane   <= mfbh_pkg::LANE_W'({i_data_bit_index, i_data_bit_state});
            r_rd_ok     <= (32'(i_addr_bit_index) < 32'(mfbh_pkg::MAX_ADDR_BITS));
            r_last_byte <= 2'(nbytes - 3'd1);
            r_last_abit <= mfbh_pkg::ABIT_W'(tracked - mfbh_pkg::TRACK_W'(1));
            r_byte      <= 2'd0;
            r_abit      <= '0;
            r_res_count <= '0;
            r_res_any   <= (in_op == mfbh_pkg::OP_RECORD) && !mis && (nfail != 3'd0);
            r_res_mis   <= (in_op == mfbh_pkg::OP_RECORD) && mis;
            r_res_bytes <= ((in_op == mfbh_pkg::OP_RECORD) && !mis) ? nfail : 3'd0;
            if (in_op == mfbh_pkg::OP_READ) begin
                if (in_target == mfbh_pkg::TGT_TESTS_TOTAL) begin
                    r_res_count <= mfbh_pkg::sat_out(r_tests_total);
                end else if (in_target == mfbh_pkg::TGT_FAILS_TOTAL) begin
                    r_res_count <= mfbh_pkg::sat_out(r_fails_total);
                end
            end
        end
        if (step_issue) begin
            r_p1_row <= issue_row;
            r_p1_exp <= r_expect[{r_byte, 3'b000} +: DB];
            r_p1_rcv <= r_receive[{r_byte, 3'b000} +: DB];
            // advance address bit, then byte
            if (r_abit == r_last_abit) begin
                r_abit <= '0;
                r_byte <= r_byte + 2'd1;
            end else begin
                r_abit <= r_abit + 1'b1;
            end
        end
        r_fwd_row <= new_row;
        if (r_state == mfbh_pkg::S_READ_DATA) begin
            r_res_count <= mfbh_pkg::sat_out(rd_val);
        end
        if (load_out) begin
            r_out_count <= r_res_count;
            r_out_any   <= r_res_any;
            r_out_mis   <= r_res_mis;
            r_out_bytes <= r_res_bytes;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_count_value  = r_out_count;
    assign o_any_mismatch = r_out_any;
    assign o_misaligned   = r_out_mis;
    assign o_bytes_failed = r_out_bytes;

endmodule

>>> sv/mfbh_checker.sv
`include "assert_macros.svh"

module mfbh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_count_value,
    input logic        o_any_mismatch,
    input logic        o_misaligned,
    input logic [2:0]  o_bytes_failed
);

    `MFBH_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid, "result beat dropped before it was taken")
    `MFBH_ASSERT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "input taken while a beat is still in work")
    `MFBH_ASSERT(a_mis_clean, i_clk, i_rst_n, o_out_valid && o_misaligned |-> o_count_value == 32'd0 && !o_any_mismatch && o_bytes_failed == 3'd0, "rejected record carries data")
    `MFBH_ASSERT(a_mismatch_flag, i_clk, i_rst_n, o_out_valid |-> (o_any_mismatch == (o_bytes_failed != 3'd0)) && o_bytes_failed <= 3'd4, "mismatch flag disagrees with byte count")
    `MFBH_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid, "result valid right after reset")

endmodule

bind memory_fail_bit_histogram mfbh_checker u_mfbh_checker (.*);

>>> bench/memory_fail_bit_histogram_tb.sv
`timescale 1ns / 100ps

module memory_fail_bit_histogram_tb;

    localparam int RANDOM_PER_PHASE = 100;
    localparam int PHASES           = 6;
    localparam int QUIET_TAIL       = 60;
    localparam int DRAIN_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int HIST_SLOTS       = mfbh_pkg::MAX_ADDR_BITS * 2 * mfbh_pkg::DATA_BITS * 2;

    typedef struct packed {
        mfbh_pkg::t_op     op;
        logic [1:0]        size;
        logic [31:0]       address;
        logic [31:0]       expected_data;
        logic [31:0]       received_data;
        mfbh_pkg::t_target target;
        logic [4:0]        abit_idx;
        logic              abit_val;
        logic [2:0]        dbit_idx;
        logic              dbit_val;
    } t_log_op;

    typedef struct packed {
        logic [31:0] count_value;
        logic        any_mismatch;
        logic        misaligned;
        logic [2:0]  bytes_failed;
    } t_log_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_op = '0;
    logic [1:0]  i_access_size = '0;
    logic [31:0] i_address = '0;
    logic [31:0] i_expected_data = '0;
    logic [31:0] i_received_data = '0;
    logic [1:0]  i_read_target = '0;
    logic [4:0]  i_addr_bit_index = '0;
    logic        i_addr_bit_state = 1'b0;
    logic [2:0]  i_data_bit_index = '0;
    logic        i_data_bit_state = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_count_value;
    logic        o_any_mismatch;
    logic        o_misaligned;
    logic [2:0]  o_bytes_failed;

    memory_fail_bit_histogram u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_access_size   (i_access_size),
        .i_address       (i_address),
        .i_expected_data (i_expected_data),
        .i_received_data (i_received_data),
        .i_read_target   (i_read_target),
        .i_addr_bit_index(i_addr_bit_index),
        .i_addr_bit_state(i_addr_bit_state),
        .i_data_bit_index(i_data_bit_index),
        .i_data_bit_state(i_data_bit_state),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_count_value   (o_count_value),
        .o_any_mismatch  (o_any_mismatch),
        .o_misaligned    (o_misaligned),
        .o_bytes_failed  (o_bytes_failed)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow of the histogram state
    mfbh_pkg::t_count test_hist [HIST_SLOTS];
    mfbh_pkg::t_count fail_hist [HIST_SLOTS];
    mfbh_pkg::t_count bytes_tested;
    mfbh_pkg::t_count bytes_failed_total;
    logic [5:0]       track_bits = mfbh_pkg::RESET_TRACK_BITS;

    t_log_op     pending_log_ops[$];
    t_log_result expected_log_results[$];
    t_log_op     in_flight;
    t_log_op     next_op;
    t_log_result got;
    t_log_result want;

    int err_count = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_records = 0;
    int n_rejected = 0;
    int n_reads = 0;
    int n_clears = 0;
    int quiet_after = 1 << 30;
    int send_gap = 0;
    int recv_stall = 0;
    bit send_idles = 1'b1;
    bit recv_idles = 1'b1;
    int stall_free = 0;

    function automatic mfbh_pkg::t_count bump_count(mfbh_pkg::t_count c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic int hist_slot(int a, logic as, int d, logic ds);
        return ((a * 2 + int'(as)) * mfbh_pkg::DATA_BITS + d) * 2 + int'(ds);
    endfunction

    function automatic t_log_result predict_histogram_op(t_log_op r);
        t_log_result rsp;
        int          nbytes;
        int          tracked;
        int          failed;
        int          slot;
        logic        misal;
        logic [31:0] baddr;
        logic [7:0]  e;
        logic [7:0]  g;
        rsp = '0;
        tracked = (track_bits > mfbh_pkg::MAX_ADDR_BITS) ? mfbh_pkg::MAX_ADDR_BITS
                                                          : int'(track_bits);
        case (r.op)
            mfbh_pkg::OP_RECORD: begin
                case (r.size)
                    mfbh_pkg::SIZE_BYTE: begin nbytes = 1; misal = 1'b0; end
                    mfbh_pkg::SIZE_HALF: begin nbytes = 2; misal = r.address[0]; end
                    mfbh_pkg::SIZE_WORD: begin nbytes = 4; misal = |r.address[1:0]; end
                    default:             begin nbytes = 0; misal = 1'b1; end
                endcase
                if (misal) begin
                    rsp.misaligned = 1'b1;
                end else begin
                    failed = 0;
                    for (int i = 0; i < nbytes; i++) begin
                        baddr = r.address + 32'(i);
                        e = r.expected_data[8*i +: 8];
                        g = r.received_data[8*i +: 8];
                        bytes_tested = bump_count(bytes_tested);
                        if (e != g) begin
                            bytes_failed_total = bump_count(bytes_failed_total);
                            failed++;
                        end
                        for (int a = 0; a < tracked; a++) begin
                            for (int d = 0; d < mfbh_pkg::DATA_BITS; d++) begin
                                slot = hist_slot(a, baddr[a], d, e[d]);
                                test_hist[slot] = bump_count(test_hist[slot]);
                                if (e[d] != g[d])
                                    fail_hist[slot] = bump_count(fail_hist[slot]);
                            end
                        end
                    end
                    rsp.any_mismatch = (failed != 0);
                    rsp.bytes_failed = 3'(failed);
                end
            end
            mfbh_pkg::OP_READ: begin
                slot = hist_slot(int'(r.abit_idx), r.abit_val, int'(r.dbit_idx), r.dbit_val);
                case (r.target)
                    mfbh_pkg::TGT_TESTS_TOTAL: rsp.count_value = bytes_tested;
                    mfbh_pkg::TGT_FAILS_TOTAL: rsp.count_value = bytes_failed_total;
                    mfbh_pkg::TGT_TEST:        rsp.count_value = test_hist[slot];
                    default:                   rsp.count_value = fail_hist[slot];
                endcase
            end
            mfbh_pkg::OP_CLEAR: begin
                foreach (test_hist[k]) begin
                    test_hist[k] = '0;
                    fail_hist[k] = '0;
                end
                bytes_tested = '0;
                bytes_failed_total = '0;
            end
            default: ;
        endcase
        return rsp;
    endfunction

    function automatic t_log_op make_op(mfbh_pkg::t_op op, logic [1:0] size,
                                        logic [31:0] addr, logic [31:0] exp_d,
                                        logic [31:0] rcv_d, mfbh_pkg::t_target tgt,
                                        logic [4:0] abi, logic abv,
                                        logic [2:0] dbi, logic dbv);
        t_log_op r;
        r.op = op;
        r.size = size;
        r.address = addr;
        r.expected_data = exp_d;
        r.received_data = rcv_d;
        r.target = tgt;
        r.abit_idx = abi;
        r.abit_val = abv;
        r.dbit_idx = dbi;
        r.dbit_val = dbv;
        return r;
    endfunction

    function automatic t_log_op random_log_op();
        t_log_op r;
        int      pick;
        r = make_op(mfbh_pkg::OP_RECORD, 2'($urandom), $urandom, $urandom, $urandom,
                    mfbh_pkg::t_target'($urandom_range(0, 3)), 5'($urandom), 1'($urandom),
                    3'($urandom), 1'($urandom));
        pick = $urandom_range(0, 199);
        if (pick < 146) begin
            pick = $urandom_range(0, 19);
            r.size = (pick < 6) ? mfbh_pkg::SIZE_BYTE : (pick < 12) ? mfbh_pkg::SIZE_HALF :
                     (pick < 19) ? mfbh_pkg::SIZE_WORD : 2'd3;
            // mostly aligned; the rest may get rejected
            if ($urandom_range(0, 7) != 0) begin
                if (r.size == mfbh_pkg::SIZE_HALF) r.address[0] = 1'b0;
                if (r.size == mfbh_pkg::SIZE_WORD) r.address[1:0] = 2'b00;
            end
            case ($urandom_range(0, 3))
                0, 1: r.received_data = r.expected_data;
                2:    r.received_data = r.expected_data ^ (32'h1 << $urandom_range(0, 31));
                default: ;
            endcase
        end else if (pick < 186) begin
            r.op = mfbh_pkg::OP_READ;
        end else if (pick < 190) begin
            r.op = mfbh_pkg::OP_CLEAR;
        end else begin
            r.op = mfbh_pkg::OP_NOP;
        end
        return r;
    endfunction

    function automatic bit predict_misaligned(t_log_op r);
        return (r.size == 2'd3) || (r.size == mfbh_pkg::SIZE_HALF && r.address[0])
            || (r.size == mfbh_pkg::SIZE_WORD && r.address[1:0] != 2'b00);
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got_v, want_v);
        err_count++;
    endtask

    // Driver: one beat in flight, random gaps between beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_log_results.push_back(predict_histogram_op(in_flight));
                case (in_flight.op)
                    mfbh_pkg::OP_RECORD: begin
                        n_records++;
                        if (predict_misaligned(in_flight)) n_rejected++;
                    end
                    mfbh_pkg::OP_READ:  n_reads++;
                    mfbh_pkg::OP_CLEAR: n_clears++;
                    default: ;
                endcase
                n_accepted++;
                if (n_accepted % 50 == 0) send_idles <= ($urandom_range(0, 2) != 0);
            end
            if (!(i_in_valid && !o_in_ready)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (send_idles && n_accepted < quiet_after
                             && $urandom_range(0, 5) == 0) begin
                    send_gap <= $urandom_range(0, 4);
                    i_in_valid <= 1'b0;
                end else if (pending_log_ops.size() != 0) begin
                    next_op = pending_log_ops.pop_front();
                    in_flight <= next_op;
                    i_op <= next_op.op;
                    i_access_size <= next_op.size;
                    i_address <= next_op.address;
                    i_expected_data <= next_op.expected_data;
                    i_received_data <= next_op.received_data;
                    i_read_target <= next_op.target;
                    i_addr_bit_index <= next_op.abit_idx;
                    i_addr_bit_state <= next_op.abit_val;
                    i_data_bit_index <= next_op.dbit_idx;
                    i_data_bit_state <= next_op.dbit_val;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result beat against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_stall <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_count_value, o_any_mismatch, o_misaligned, o_bytes_failed};
                if (expected_log_results.size() == 0) begin
                    flag_mismatch("unexpected result beat", got.count_value, 32'd0);
                end else begin
                    want = expected_log_results.pop_front();
                    if (got.count_value !== want.count_value)
                        flag_mismatch("count_value", got.count_value, want.count_value);
                    if (got.any_mismatch !== want.any_mismatch)
                        flag_mismatch("any_mismatch", 32'(got.any_mismatch),
                                      32'(want.any_mismatch));
                    if (got.misaligned !== want.misaligned)
                        flag_mismatch("misaligned", 32'(got.misaligned), 32'(want.misaligned));
                    if (got.bytes_failed !== want.bytes_failed)
                        flag_mismatch("bytes_failed", 32'(got.bytes_failed),
                                      32'(want.bytes_failed));
                end
                n_results++;
                if (n_results % 40 == 0) recv_idles <= ($urandom_range(0, 2) != 0);
            end
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                i_out_ready <= 1'b0;
            end else if (recv_idles && n_accepted < quiet_after
                         && $urandom_range(0, 4) == 0) begin
                recv_stall <= $urandom_range(0, 4);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (psel && penable)) begin
            stall_free <= 0;
        end else if (stall_free >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL memory_fail_bit_histogram");
            $finish;
        end else begin
            stall_free <= stall_free + 1;
        end
    end

    task automatic wait_until_idle();
        @(negedge i_clk);
        while (pending_log_ops.size() != 0 || i_in_valid || expected_log_results.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_track_bits(logic [5:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(mfbh_pkg::REG_TRACK_BITS * 4);
        pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        track_bits = value;
    endtask

    task automatic add_record(logic [1:0] size, logic [31:0] addr, logic [31:0] exp_d,
                              logic [31:0] rcv_d);
        pending_log_ops.push_back(make_op(mfbh_pkg::OP_RECORD, size, addr, exp_d, rcv_d,
                                          mfbh_pkg::TGT_TEST, 5'd0, 1'b0, 3'd0, 1'b0));
    endtask

    task automatic add_read(mfbh_pkg::t_target tgt, logic [4:0] abi, logic abv,
                            logic [2:0] dbi, logic dbv);
        pending_log_ops.push_back(make_op(mfbh_pkg::OP_READ, mfbh_pkg::SIZE_BYTE, 32'h0,
                                          32'h0, 32'h0, tgt, abi, abv, dbi, dbv));
    endtask

    // Directed beats, run with all 32 address bits tracked
    task automatic push_directed();
        add_record(mfbh_pkg::SIZE_BYTE, 32'h0, 32'h0, 32'h0);
        add_record(mfbh_pkg::SIZE_BYTE, 32'hFFFF_FFFF, 32'hFF, 32'h00);
        add_record(mfbh_pkg::SIZE_HALF, 32'hFFFF_FFFE, 32'hFFFF, 32'hFFFF);
        add_record(mfbh_pkg::SIZE_WORD, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'h0);
        add_record(mfbh_pkg::SIZE_WORD, 32'h10, 32'h1234_5678, 32'h1234_0678);
        // rejected records: odd halfword, unaligned words, invalid size
        add_record(mfbh_pkg::SIZE_HALF, 32'h1, 32'hAAAA, 32'h5555);
        add_record(mfbh_pkg::SIZE_WORD, 32'h2, 32'h0, 32'hFFFF_FFFF);
        add_record(mfbh_pkg::SIZE_WORD, 32'h3, 32'h0, 32'h1);
        add_record(2'd3, 32'h0, 32'h0, 32'hFF);
        pending_log_ops.push_back(make_op(mfbh_pkg::OP_NOP, mfbh_pkg::SIZE_WORD,
                                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                                          mfbh_pkg::TGT_FAILS_TOTAL, 5'd31, 1'b1, 3'd7, 1'b1));
        add_read(mfbh_pkg::TGT_TESTS_TOTAL, 5'd0, 1'b0, 3'd0, 1'b0);
        add_read(mfbh_pkg::TGT_FAILS_TOTAL, 5'd0, 1'b0, 3'd0, 1'b0);
        add_read(mfbh_pkg::TGT_TEST, 5'd0, 1'b0, 3'd0, 1'b0);
        add_read(mfbh_pkg::TGT_FAIL, 5'd31, 1'b1, 3'd7, 1'b1);
        add_read(mfbh_pkg::TGT_TEST, 5'd31, 1'b1, 3'd7, 1'b1);
        add_read(mfbh_pkg::TGT_FAIL, 5'd0, 1'b0, 3'd0, 1'b1);
        pending_log_ops.push_back(make_op(mfbh_pkg::OP_CLEAR, mfbh_pkg::SIZE_BYTE, 32'h0,
                                          32'h0, 32'h0, mfbh_pkg::TGT_TEST,
                                          5'd0, 1'b0, 3'd0, 1'b0));
        add_read(mfbh_pkg::TGT_TESTS_TOTAL, 5'd0, 1'b0, 3'd0, 1'b0);
        add_read(mfbh_pkg::TGT_TEST, 5'd31, 1'b1, 3'd7, 1'b1);
    endtask

    logic [5:0] phase_bits [PHASES];
    int         directed_count;

    initial begin
        foreach (test_hist[k]) begin
            test_hist[k] = '0;
            fail_hist[k] = '0;
        end
        bytes_tested = '0;
        bytes_failed_total = '0;
        // extremes first: full width, one bit, none, above the maximum
        phase_bits = '{6'd32, 6'd1, 6'd0, 6'd63, 6'($urandom_range(2, 31)), 6'd32};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            wait_until_idle();
            write_track_bits(phase_bits[p]);
            @(negedge i_clk);
            if (p == 0) begin
                push_directed();
                directed_count = pending_log_ops.size();
                quiet_after = directed_count + PHASES * RANDOM_PER_PHASE - QUIET_TAIL;
            end
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
                pending_log_ops.push_back(random_log_op());
        end

        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_log_results.size() != 0)
            flag_mismatch("results never returned", 32'(expected_log_results.size()), 32'd0);

        $display("Checked %0d results from %0d beats: %0d records (%0d rejected), %0d reads,",
                 n_results, n_accepted, n_records, n_rejected, n_reads);
        $display("%0d clears, over %0d address-bit settings.", n_clears, PHASES);
        if (err_count == 0) begin
            $display("PASS memory_fail_bit_histogram");
        end else begin
            $display("FAIL memory_fail_bit_histogram");
        end
        $finish;
    end

endmodule
